>>> design/qple_pkg.sv
// Shared constants, command and status types for the quoted-printable line encoder.
package qple_pkg;

    localparam int LINE_LIMIT_DEFAULT = 76;

    localparam logic [1:0] MODE_DATA  = 2'd0;
    localparam logic [1:0] MODE_EOL   = 2'd1;
    localparam logic [1:0] MODE_DRAIN = 2'd2;

    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [3:0] QUOTE_WIDTH = 4'd3;
    localparam logic [3:0] TAB_STOP    = 4'd8;

    typedef struct packed {
        logic load_in;
        logic add;
        logic fix_last;
        logic scan_init;
        logic scan_rd;
        logic scan_use;
        logic pick;
        logic emit_init_hard;
        logic emit_rd;
        logic emit_char;
        logic emit_eq;
        logic emit_nl;
        logic shift_init;
        logic shift_rd;
        logic shift_wr;
        logic shift_end;
        logic clear_line;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       byte_nl;
        logic       fill_zero;
        logic       long_line;
        logic       last_blank;
        logic       idx_at_fill;
        logic       idx_at_cut;
        logic       glyph_done;
        logic       soft_cut;
        logic       char_ready;
        logic       acc_empty;
        logic       out_free;
    } status_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
    endfunction

endpackage

>>> design/qple_datapath.sv
// Datapath of the quoted-printable line encoder: glyph memory, line scan and output packer.
module qple_datapath #(
    parameter int LINE_LIMIT = qple_pkg::LINE_LIMIT_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  logic [7:0]       s_tdata,
    input  logic [1:0]       s_tuser,
    input  qple_pkg::cmd_t   cmd,
    output qple_pkg::status_t status,
    output logic [71:0]      m_tdata,
    output logic             m_tlast,
    output logic             m_tvalid,
    input  logic             m_tready
);

    localparam int DEPTH = LINE_LIMIT + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int COLW  = $clog2(LINE_LIMIT + 9);
    localparam logic [COLW-1:0] LIM = COLW'(LINE_LIMIT);

    // Glyph entry: byte, quote flag, width.
    logic [12:0] mem [DEPTH];
    logic [12:0] rd_reg;

    logic            intl_reg;
    logic [1:0]      mode_reg;
    logic [7:0]      byte_reg;
    logic [CW-1:0]   fill_reg, idx_reg, cut_reg, cutmax_reg, blank_reg;
    logic [COLW-1:0] total_reg, run_reg, colmax_reg, colblank_reg, col0_reg, cutcol_reg;
    logic [7:0]      last_byte_reg;
    logic [3:0]      last_w_reg;
    logic [1:0]      sub_reg;
    logic            soft_reg;
    logic [63:0]     acc_reg, out_data_reg;
    logic [3:0]      acc_cnt_reg, out_cnt_reg;
    logic            out_last_reg, out_valid_reg;

    logic [7:0]      rd_byte;
    logic            rd_quote;
    logic [3:0]      rd_width;
    logic [COLW-1:0] scan_col;
    logic [3:0]      new_w;
    logic            new_q;
    logic            unprint, space_cls;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [12:0]     mem_wd;
    logic            char_valid;
    logic [7:0]      char_val;
    logic            glyph_done;
    logic            char_ready;

    assign rd_byte  = rd_reg[12:5];
    assign rd_quote = rd_reg[4];
    assign rd_width = rd_reg[3:0];
    assign scan_col = run_reg + COLW'(rd_width);

    always_comb begin
        unprint   = intl_reg ? (byte_reg < 8'd32) : ((byte_reg < 8'd32) || (byte_reg > 8'd126));
        space_cls = ((byte_reg >= 8'd9) && (byte_reg <= 8'd13)) || (byte_reg == qple_pkg::CHAR_SPACE);
        new_w = 4'd1;
        new_q = 1'b0;
        if (byte_reg == qple_pkg::CHAR_EQ) begin
            new_w = qple_pkg::QUOTE_WIDTH;
            new_q = 1'b1;
        end else if (byte_reg == qple_pkg::CHAR_TAB) begin
            new_w = qple_pkg::TAB_STOP - {1'b0, total_reg[2:0]};
        end else if (unprint && !space_cls) begin
            new_w = qple_pkg::QUOTE_WIDTH;
            new_q = 1'b1;
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = fill_reg[AW-1:0];
        mem_wd = {byte_reg, new_q, new_w};
        if (cmd.add) begin
            mem_we = 1'b1;
        end else if (cmd.fix_last) begin
            mem_we = 1'b1;
            mem_wa = AW'(fill_reg - CW'(1));
            mem_wd = {last_byte_reg, 1'b1, qple_pkg::QUOTE_WIDTH};
        end else if (cmd.shift_wr) begin
            mem_we = 1'b1;
            mem_wa = AW'(idx_reg - cut_reg);
            mem_wd = rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.scan_rd || cmd.emit_rd || cmd.shift_rd) begin
            rd_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    assign glyph_done = !rd_quote || (sub_reg == 2'd2);
    assign char_ready = (acc_cnt_reg != 4'd8) || !out_valid_reg;

    always_comb begin
        char_valid = cmd.emit_char || cmd.emit_eq || cmd.emit_nl;
        char_val   = qple_pkg::CHAR_NL;
        if (cmd.emit_eq) begin
            char_val = qple_pkg::CHAR_EQ;
        end else if (cmd.emit_char) begin
            if (!rd_quote) begin
                char_val = rd_byte;
            end else begin
                case (sub_reg)
                    2'd0:    char_val = qple_pkg::CHAR_EQ;
                    2'd1:    char_val = qple_pkg::hex_char(rd_byte[7:4]);
                    default: char_val = qple_pkg::hex_char(rd_byte[3:0]);
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            intl_reg      <= 1'b0;
            fill_reg      <= '0;
            total_reg     <= '0;
            acc_reg       <= '0;
            acc_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                intl_reg <= cfg_wr_data;
            end
            if (cmd.add) begin
                fill_reg      <= fill_reg + CW'(1);
                total_reg     <= total_reg + COLW'(new_w);
                last_byte_reg <= byte_reg;
                last_w_reg    <= new_w;
            end
            if (cmd.fix_last) begin
                total_reg  <= total_reg - COLW'(last_w_reg) + COLW'(qple_pkg::QUOTE_WIDTH);
                last_w_reg <= qple_pkg::QUOTE_WIDTH;
            end
            if (cmd.shift_end) begin
                fill_reg  <= fill_reg - cut_reg;
                total_reg <= total_reg - cutcol_reg;
            end
            if (cmd.clear_line) begin
                fill_reg  <= '0;
                total_reg <= '0;
            end
            // Packer: a full accumulator moves to the output register when the next char arrives, or on a flush.
            if (char_valid) begin
                if (acc_cnt_reg == 4'd8) begin
                    acc_reg     <= {56'd0, char_val};
                    acc_cnt_reg <= 4'd1;
                end else begin
                    acc_reg[acc_cnt_reg[2:0]*8 +: 8] <= char_val;
                    acc_cnt_reg <= acc_cnt_reg + 4'd1;
                end
            end else if (cmd.flush) begin
                acc_reg     <= '0;
                acc_cnt_reg <= '0;
            end
            // The output register is released by a handshake even while chars keep arriving.
            if ((char_valid && (acc_cnt_reg == 4'd8)) || cmd.flush) begin
                out_data_reg  <= acc_reg;
                out_cnt_reg   <= acc_cnt_reg;
                out_last_reg  <= cmd.flush;
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg <= s_tuser;
            byte_reg <= s_tdata;
        end
        if (cmd.scan_init) begin
            idx_reg    <= '0;
            run_reg    <= '0;
            cutmax_reg <= '0;
            blank_reg  <= '0;
        end
        if (cmd.scan_use) begin
            if (scan_col < LIM) begin
                cutmax_reg <= idx_reg + CW'(1);
                colmax_reg <= scan_col;
                if (qple_pkg::is_blank(rd_byte)) begin
                    blank_reg    <= idx_reg + CW'(1);
                    colblank_reg <= scan_col;
                end
            end
            if (idx_reg == '0) begin
                col0_reg <= scan_col;
            end
            run_reg <= scan_col;
            idx_reg <= idx_reg + CW'(1);
        end
        if (cmd.pick) begin
            if (blank_reg != '0) begin
                cut_reg    <= blank_reg;
                cutcol_reg <= colblank_reg;
            end else if (cutmax_reg != '0) begin
                cut_reg    <= cutmax_reg;
                cutcol_reg <= colmax_reg;
            end else begin
                cut_reg    <= CW'(1);
                cutcol_reg <= col0_reg;
            end
            idx_reg  <= '0;
            sub_reg  <= '0;
            soft_reg <= 1'b1;
        end
        if (cmd.emit_init_hard) begin
            cut_reg  <= fill_reg;
            idx_reg  <= '0;
            sub_reg  <= '0;
            soft_reg <= 1'b0;
        end
        if (cmd.emit_char) begin
            if (glyph_done) begin
                sub_reg <= '0;
                idx_reg <= idx_reg + CW'(1);
            end else begin
                sub_reg <= sub_reg + 2'd1;
            end
        end
        if (cmd.shift_init) begin
            idx_reg <= cut_reg;
        end
        if (cmd.shift_wr) begin
            idx_reg <= idx_reg + CW'(1);
        end
    end

    always_comb begin
        status.mode        = mode_reg;
        status.byte_nl     = (byte_reg == qple_pkg::CHAR_NL);
        status.fill_zero   = (fill_reg == '0);
        status.long_line   = (total_reg > LIM);
        status.last_blank  = qple_pkg::is_blank(last_byte_reg);
        status.idx_at_fill = (idx_reg == fill_reg);
        status.idx_at_cut  = (idx_reg == cut_reg);
        status.glyph_done  = glyph_done;
        status.soft_cut    = soft_reg;
        status.char_ready  = char_ready;
        status.acc_empty   = (acc_cnt_reg == 4'd0);
        status.out_free    = !out_valid_reg;
    end

    assign m_tdata  = {4'd0, out_cnt_reg, out_data_reg};
    assign m_tlast  = out_last_reg;
    assign m_tvalid = out_valid_reg;

endmodule

>>> design/qple_ctrl.sv
// Controller state machine of the quoted-printable line encoder.
module qple_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  qple_pkg::status_t status,
    output qple_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_HN       = 4'd2;
    localparam logic [3:0] S_CHECK    = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_USE = 4'd5;
    localparam logic [3:0] S_PICK     = 4'd6;
    localparam logic [3:0] S_EMIT_RD  = 4'd7;
    localparam logic [3:0] S_EMIT_CH  = 4'd8;
    localparam logic [3:0] S_EMIT_EQ  = 4'd9;
    localparam logic [3:0] S_EMIT_NL  = 4'd10;
    localparam logic [3:0] S_SHIFT_RD = 4'd11;
    localparam logic [3:0] S_SHIFT_WR = 4'd12;
    localparam logic [3:0] S_FLUSH    = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       drain_reg, drain_next;
    logic       hn_reg, hn_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        drain_next = drain_reg;
        hn_next    = hn_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                drain_next = 1'b0;
                hn_next    = 1'b0;
                case (status.mode)
                    qple_pkg::MODE_DATA: begin
                        if (status.byte_nl) begin
                            state_next = S_HN;
                        end else begin
                            cmd.add    = 1'b1;
                            state_next = S_CHECK;
                        end
                    end
                    qple_pkg::MODE_EOL: begin
                        state_next = status.fill_zero ? S_FLUSH : S_HN;
                    end
                    qple_pkg::MODE_DRAIN: begin
                        drain_next = 1'b1;
                        state_next = S_CHECK;
                    end
                    default: state_next = S_FLUSH;
                endcase
            end
            S_HN: begin
                if (!status.fill_zero && status.last_blank) begin
                    cmd.fix_last = 1'b1;
                end
                hn_next    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (!status.fill_zero && (drain_reg || status.long_line)) begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN_RD;
                end else if (hn_reg) begin
                    cmd.emit_init_hard = 1'b1;
                    state_next         = S_EMIT_RD;
                end else begin
                    state_next = S_FLUSH;
                end
            end
            S_SCAN_RD: begin
                if (status.idx_at_fill) begin
                    state_next = S_PICK;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_USE;
                end
            end
            S_SCAN_USE: begin
                cmd.scan_use = 1'b1;
                state_next   = S_SCAN_RD;
            end
            S_PICK: begin
                cmd.pick   = 1'b1;
                state_next = S_EMIT_RD;
            end
            S_EMIT_RD: begin
                if (status.idx_at_cut) begin
                    state_next = status.soft_cut ? S_EMIT_EQ : S_EMIT_NL;
                end else begin
                    cmd.emit_rd = 1'b1;
                    state_next  = S_EMIT_CH;
                end
            end
            S_EMIT_CH: begin
                if (status.char_ready) begin
                    cmd.emit_char = 1'b1;
                    if (status.glyph_done) begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_EMIT_EQ: begin
                if (status.char_ready) begin
                    cmd.emit_eq = 1'b1;
                    state_next  = S_EMIT_NL;
                end
            end
            S_EMIT_NL: begin
                if (status.char_ready) begin
                    cmd.emit_nl = 1'b1;
                    if (status.soft_cut) begin
                        cmd.shift_init = 1'b1;
                        state_next     = S_SHIFT_RD;
                    end else begin
                        cmd.clear_line = 1'b1;
                        state_next     = S_FLUSH;
                    end
                end
            end
            S_SHIFT_RD: begin
                if (status.idx_at_fill) begin
                    cmd.shift_end = 1'b1;
                    state_next    = S_CHECK;
                end else begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_FLUSH: begin
                if (status.acc_empty) begin
                    state_next = S_IDLE;
                end else if (status.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            drain_reg <= 1'b0;
            hn_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            drain_reg <= drain_next;
            hn_reg    <= hn_next;
        end
    end

endmodule

>>> design/quoted_printable_line_encoder.sv
// Top level of the quoted-printable line encoder: controller plus datapath.
//
// Input requests arrive on the s_ channel: s_tdata carries the raw byte and
// s_tuser the mode (data byte, end of line, or close and drain). Encoded text
// leaves on the m_ channel, up to eight characters per request in the low 64
// bits of m_tdata, the character count above them, and m_tlast marking the
// final output request caused by one input request.
// A soft line break scans the buffered glyphs for the cut, writes out the
// glyphs before the cut, and shifts the remaining glyphs down in the glyph
// memory. Output requests leave through a register, so the packer keeps
// filling the next word while one waits.
// If the receiver stalls, character generation pauses once the next word is
// full, and no input request is taken until all output of the current one is
// queued. Reset empties the line buffer and the packer and clears
// international_mode; the glyph memory itself needs no clearing.
module quoted_printable_line_encoder #(
    parameter int LINE_LIMIT = qple_pkg::LINE_LIMIT_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // international_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // data_byte
    input  logic [1:0]  s_tuser,       // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,       // chars [63:0], char_count [67:64], zero pad
    output logic        m_tlast        // last
);

    qple_pkg::cmd_t    cmd;
    qple_pkg::status_t status;

    qple_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qple_datapath #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .status      (status),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready)
    );

endmodule

>>> sim/tb_quoted_printable_line_encoder.sv
// Self-checking testbench for the quoted-printable line encoder.
module tb_quoted_printable_line_encoder;

    localparam int LIMIT = 76;
    localparam int DEPTH = LIMIT + 1;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [63:0] chars;
        logic [3:0]  count;
        logic        last;
    } out_word_t;

    typedef struct {
        logic [7:0] ch;
        logic       quoted;
        int         width;
        int         column;
    } glyph_t;

    // The scoreboard carries its own copy of the line buffer and the packed
    // output words that are still due from the encoder.
    class line_scoreboard;
        glyph_t    line_buf[DEPTH];
        int        fill;
        logic      intl;
        byte       text[$];
        out_word_t due_words[$];
        int        errors;

        function new();
            fill = 0;
            intl = 0;
            errors = 0;
        endfunction

        function logic [7:0] to_hex(logic [3:0] n);
            return (n < 10) ? 8'd48 + n : 8'd55 + n;
        endfunction

        function bit blank(logic [7:0] c);
            return c == qple_pkg::CHAR_SPACE || c == qple_pkg::CHAR_TAB;
        endfunction

        function void put_line(int n, bit soft_brk);
            for (int i = 0; i < n; i++) begin
                if (line_buf[i].quoted) begin
                    text.push_back(qple_pkg::CHAR_EQ);
                    text.push_back(to_hex(line_buf[i].ch[7:4]));
                    text.push_back(to_hex(line_buf[i].ch[3:0]));
                end else begin
                    text.push_back(line_buf[i].ch);
                end
            end
            if (soft_brk) text.push_back(qple_pkg::CHAR_EQ);
            text.push_back(qple_pkg::CHAR_NL);
        endfunction

        function void break_line();
            int cut, cut_max;
            cut = fill;
            if (fill == 0) return;
            while (cut > 0 && line_buf[cut-1].column >= LIMIT) cut--;
            cut_max = cut;
            while (cut > 0 && !blank(line_buf[cut-1].ch)) cut--;
            if (cut == 0) cut = cut_max;
            if (cut == 0) cut = 1;
            put_line(cut, 1);
            for (int j = 0; j + cut < fill; j++) begin
                line_buf[j] = line_buf[j+cut];
                line_buf[j].column = (j ? line_buf[j-1].column : 0) + line_buf[j].width;
            end
            fill -= cut;
        endfunction

        function void break_long();
            while (fill > 0 && line_buf[fill-1].column > LIMIT) break_line();
        endfunction

        function void end_line();
            if (fill > 0 && blank(line_buf[fill-1].ch)) begin
                line_buf[fill-1].column += 3 - line_buf[fill-1].width;
                line_buf[fill-1].width = 3;
                line_buf[fill-1].quoted = 1;
                break_long();
            end
            put_line(fill, 0);
            fill = 0;
        endfunction

        function void append(logic [7:0] c);
            int col;
            if (c == qple_pkg::CHAR_NL) begin
                end_line();
                return;
            end
            if (fill >= DEPTH) fill = DEPTH - 1;
            col = fill ? line_buf[fill-1].column : 0;
            line_buf[fill].ch = c;
            line_buf[fill].width = 1;
            line_buf[fill].quoted = 0;
            if (c == qple_pkg::CHAR_EQ) begin
                line_buf[fill].width = 3;
                line_buf[fill].quoted = 1;
            end else if (c == qple_pkg::CHAR_TAB) begin
                line_buf[fill].width = ((col + 8) & ~7) - col;
            end else if ((c < 32 || (!intl && c > 126)) && !(c >= 9 && c <= 13)) begin
                line_buf[fill].width = 3;
                line_buf[fill].quoted = 1;
            end
            line_buf[fill].column = col + line_buf[fill].width;
            fill++;
            break_long();
        endfunction

        // Notes one accepted input request and queues the words it produces.
        function void note_request(logic [1:0] mode, logic [7:0] c);
            int n, k, cnt;
            out_word_t w;
            text.delete();
            if (mode == qple_pkg::MODE_DATA) append(c);
            else if (mode == qple_pkg::MODE_EOL) begin
                if (fill > 0) end_line();
            end else if (mode == qple_pkg::MODE_DRAIN) begin
                while (fill > 0) break_line();
            end
            n = (text.size() + 7) / 8;
            for (k = 0; k < n; k++) begin
                cnt = text.size() - k * 8;
                if (cnt > 8) cnt = 8;
                w = '0;
                for (int i = 0; i < cnt; i++) w.chars[8*i +: 8] = text[k*8+i];
                w.count = 4'(cnt);
                w.last = (k == n - 1);
                due_words.push_back(w);
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50) $display("MISMATCH: %s", msg);
        endtask

        // Compares one accepted output request with the oldest due word.
        task check_word(logic [71:0] data, logic lst);
            out_word_t w;
            if (due_words.size() == 0) begin
                report("output with nothing due");
                return;
            end
            w = due_words.pop_front();
            if (data[63:0] !== w.chars) report($sformatf("chars %h, due %h", data[63:0], w.chars));
            if (data[67:64] !== w.count) report($sformatf("count %0d, due %0d", data[67:64], w.count));
            if (data[71:68] !== 4'd0) report("nonzero pad bits");
            if (lst !== w.last) report($sformatf("last %b, due %b", lst, w.last));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // data_byte
    logic [1:0]  s_tuser;    // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;    // chars [63:0], char_count [67:64], zero pad
    logic        m_tlast;

    line_scoreboard board;
    int     send_idle_pct;
    int     recv_idle_pct;
    longint cycles;

    quoted_printable_line_encoder DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("tb_quoted_printable_line_encoder: done, errors");
                $finish;
            end
        end
    end

    // Receiver side: random stall on m_tready, check every accepted word.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_word(m_tdata, m_tlast);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sends one request, idling beforehand at the current sender rate.
    // s_tvalid stays high after acceptance until the next idle or settle.
    task send(logic [1:0] mode, logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= mode;
        s_tdata <= c;
        do @(posedge aclk); while (!s_tready);
        board.note_request(mode, c);
    endtask

    // Waits until every due word has come, plus a margin for busy work.
    task settle();
        s_tvalid <= 0;
        while (board.due_words.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task set_intl(logic v);
        settle();
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge aclk);
        board.intl = v;
        cfg_wr_en <= 0;
    endtask

    // Mostly printable text with spaces, tabs and newlines, plus odd bytes.
    function logic [7:0] text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 8'($urandom_range(33, 126));
        if (r < 67) return qple_pkg::CHAR_SPACE;
        if (r < 72) return qple_pkg::CHAR_TAB;
        if (r < 76) return qple_pkg::CHAR_NL;
        if (r < 80) return qple_pkg::CHAR_EQ;
        return 8'($urandom_range(255));
    endfunction

    task random_phase(int items);
        int r;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(99);
            if (r < 88) send(qple_pkg::MODE_DATA, text_byte());
            else if (r < 94) send(qple_pkg::MODE_EOL, 8'($urandom_range(255)));
            else if (r < 98) send(qple_pkg::MODE_DRAIN, 8'($urandom_range(255)));
            else send(2'd3, 8'($urandom_range(255)));
        end
    endtask

    initial begin
        board = new();
        aresetn = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        m_tready = 0;
        send_idle_pct = 13;
        recv_idle_pct = 62;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty end of line and drain, extremes, quoting, blanks.
        send(qple_pkg::MODE_EOL, 8'h00);
        send(qple_pkg::MODE_DRAIN, 8'hFF);
        send(qple_pkg::MODE_DATA, qple_pkg::CHAR_NL);
        send(qple_pkg::MODE_DATA, 8'h00);
        send(qple_pkg::MODE_DATA, 8'hFF);
        send(qple_pkg::MODE_DATA, qple_pkg::CHAR_EQ);
        send(qple_pkg::MODE_DATA, 8'h7F);
        send(qple_pkg::MODE_DATA, 8'h0B);
        send(qple_pkg::MODE_DATA, 8'h0D);
        send(qple_pkg::MODE_DATA, qple_pkg::CHAR_TAB);
        send(qple_pkg::MODE_DATA, qple_pkg::CHAR_NL);   // trailing tab gets quoted
        send(qple_pkg::MODE_DATA, 8'h41);
        send(qple_pkg::MODE_DATA, qple_pkg::CHAR_SPACE);
        send(qple_pkg::MODE_EOL, 8'h00);      // trailing space gets quoted
        send(2'd3, 8'h55);
        send(qple_pkg::MODE_DATA, 8'hAA);
        send(qple_pkg::MODE_DRAIN, 8'h00);
        // Long line without blanks forces a break at the limit.
        for (int i = 0; i < 80; i++) send(qple_pkg::MODE_DATA, 8'(8'h61 + i % 26));
        send(qple_pkg::MODE_DRAIN, 8'h00);

        set_intl(1);
        send(qple_pkg::MODE_DATA, 8'hE9);
        send(qple_pkg::MODE_DATA, 8'h80);
        send(qple_pkg::MODE_DATA, 8'h1F);
        send(qple_pkg::MODE_EOL, 8'h00);
        random_phase(55);
        send(qple_pkg::MODE_DRAIN, 8'h00);

        set_intl(0);
        send_idle_pct = 62;
        recv_idle_pct = 13;
        random_phase(55);
        send(qple_pkg::MODE_DRAIN, 8'h00);

        set_intl(1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(30);
        set_intl(0);
        random_phase(25);
        send(qple_pkg::MODE_DRAIN, 8'h00);

        settle();
        if (board.errors == 0 && board.due_words.size() == 0)
            $display("tb_quoted_printable_line_encoder: done, clean");
        else
            $display("tb_quoted_printable_line_encoder: done, errors");
        $finish;
    end
endmodule

>>> filelist.f
design/qple_pkg.sv
design/qple_datapath.sv
design/qple_ctrl.sv
design/quoted_printable_line_encoder.sv
sim/tb_quoted_printable_line_encoder.sv
